// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mfd_pkg.sv =====
package mfd_pkg;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_CSUM = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_MISMATCH   = 2'd1,
    ST_OVER_LIMIT = 2'd2
  } status_t;

  localparam logic [0:0] REG_MARKER_VALUE = 1'b0;
  localparam logic [0:0] REG_MAX_PAYLOAD  = 1'b1;

  localparam logic [7:0] MARKER_RESET      = 8'h7E;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd127;

endpackage

// ===== rtl/core/marker_frame_deframer_checker_unit.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         in_valid / in_ready       rx_byte
// output    out        out_valid / out_ready     payload_byte, has_byte, seq_number,
//                                                frame_type, is_last, status
// config    in         cfg_write_en              cfg_index, cfg_data
//
// One input transaction is taken per cycle while in_ready is high; its result,
// if any, appears in the output register in the cycle after acceptance.
// The frame state and the output register are updated in the same single pass.
// A new transaction is taken while the output register is empty or being drained.
// Reset is synchronous and returns the block to hunting for the marker.
`include "assert_macros.svh"

module marker_frame_deframer_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic [4:0] seq_number,
  output logic [3:0] frame_type,
  output logic       is_last,
  output logic [1:0] status,
  input  logic       cfg_write_en,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] marker_value;
  logic [7:0] max_payload;

  mfd_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] header_seq_type, header_seq_type_next;
  logic [7:0] received_sum, received_sum_next;
  logic [7:0] running_sum, running_sum_next;

  logic       emit;
  logic [7:0] res_byte;
  logic       res_has;
  logic       res_hdr;
  logic       res_last;
  logic [1:0] res_status;
  logic [7:0] sum_plus;
  logic [7:0] left_minus;
  logic [7:0] hdr_sel;
  logic       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign sum_plus   = running_sum + rx_byte;
  assign left_minus = bytes_left - 8'd1;

  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    header_seq_type_next = header_seq_type;
    received_sum_next    = received_sum;
    running_sum_next     = running_sum;
    emit                 = 1'b0;
    res_byte             = 8'd0;
    res_has              = 1'b0;
    res_hdr              = 1'b0;
    res_last             = 1'b0;
    res_status           = mfd_pkg::ST_GOOD;
    case (phase)
      mfd_pkg::PH_LEN: begin
        if (rx_byte > max_payload) begin
          phase_next      = mfd_pkg::PH_HUNT;
          bytes_left_next = 8'd0;
          emit            = 1'b1;
          res_last        = 1'b1;
          res_status      = mfd_pkg::ST_OVER_LIMIT;
        end else begin
          bytes_left_next  = rx_byte;
          running_sum_next = rx_byte;
          phase_next       = mfd_pkg::PH_HDR;
        end
      end
      mfd_pkg::PH_HDR: begin
        header_seq_type_next = rx_byte;
        running_sum_next     = sum_plus;
        phase_next           = mfd_pkg::PH_CSUM;
      end
      mfd_pkg::PH_CSUM: begin
        received_sum_next = rx_byte;
        if (bytes_left == 8'd0) begin
          phase_next = mfd_pkg::PH_HUNT;
          emit       = 1'b1;
          res_hdr    = 1'b1;
          res_last   = 1'b1;
          res_status = (running_sum == rx_byte) ? mfd_pkg::ST_GOOD : mfd_pkg::ST_MISMATCH;
        end else begin
          phase_next = mfd_pkg::PH_DATA;
        end
      end
      mfd_pkg::PH_DATA: begin
        running_sum_next = sum_plus;
        bytes_left_next  = left_minus;
        emit             = 1'b1;
        res_byte         = rx_byte;
        res_has          = 1'b1;
        res_hdr          = 1'b1;
        if (left_minus == 8'd0) begin
          phase_next = mfd_pkg::PH_HUNT;
          res_last   = 1'b1;
          res_status = (sum_plus == received_sum) ? mfd_pkg::ST_GOOD : mfd_pkg::ST_MISMATCH;
        end
      end
      default: begin
        phase_next = (rx_byte == marker_value) ? mfd_pkg::PH_LEN : mfd_pkg::PH_HUNT;
      end
    endcase
  end

  assign hdr_sel = res_hdr ? header_seq_type : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_value <= mfd_pkg::MARKER_RESET;
      max_payload  <= mfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        mfd_pkg::REG_MARKER_VALUE: marker_value <= cfg_data;
        mfd_pkg::REG_MAX_PAYLOAD:  max_payload  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mfd_pkg::PH_HUNT;
      bytes_left      <= 8'd0;
      header_seq_type <= 8'd0;
      received_sum    <= 8'd0;
      running_sum     <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      header_seq_type <= header_seq_type_next;
      received_sum    <= received_sum_next;
      running_sum     <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      payload_byte <= res_byte;
      has_byte     <= res_has;
      seq_number   <= hdr_sel[7:3];
      frame_type   <= hdr_sel[3:0];
      is_last      <= res_last;
      status       <= res_status;
    end
  end

  `ASSERT_SAME_CYCLE(a_empty_is_last, clk, rst, out_valid && !has_byte, is_last, "Empty result not final.")
  `ASSERT_SAME_CYCLE(a_status_only_last, clk, rst, out_valid && (status != mfd_pkg::ST_GOOD), is_last && (status != 2'd3), "Bad status on a non-final result.")
  `ASSERT_SAME_CYCLE(a_abort_no_header, clk, rst, out_valid && (status == mfd_pkg::ST_OVER_LIMIT), (seq_number == 5'd0) && (frame_type == 4'd0) && !has_byte, "Aborted frame carries header or data.")
  `ASSERT_NEXT_CYCLE(a_hunt_silent, clk, rst, accept && (phase == mfd_pkg::PH_HUNT), !out_valid, "Result produced while hunting.")

endmodule
